/* rtl/clcd_pkg.sv */
package clcd_pkg;

    localparam int COLUMNS = 20;
    localparam int ROWS    = 2;
    localparam int DEPTH   = ROWS * COLUMNS;
    localparam int AW      = $clog2(DEPTH);
    localparam int COL_W   = 5;

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_CLEAR   = 2'd1;
    localparam logic [1:0] OP_REFRESH = 2'd2;
    localparam logic [1:0] OP_INIT    = 2'd3;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_BYTE   = 2'd1;
    localparam logic [1:0] KIND_NIBBLE = 2'd2;

    localparam logic RS_CMD  = 1'b0;
    localparam logic RS_DATA = 1'b1;

    localparam logic [7:0] CMD_ROW0     = 8'h80;
    localparam logic [7:0] CMD_ROW1     = 8'hC0;
    localparam logic [7:0] START_NIBBLE = 8'h02;
    localparam logic [7:0] SPACE_CHAR   = 8'h20;

    // controller -> datapath
    typedef struct packed {
        logic             capture;
        logic             load;
        logic [1:0]       kind;
        logic             rs;
        logic             use_mem;
        logic [7:0]       value;
        logic             last;
        logic             do_write;
        logic             do_clear;
        logic             clr_dirty;
        logic             rd_row;
        logic [COL_W-1:0] rd_col;
    } clcd_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic slot_free;
    } clcd_stat_t;

    function automatic logic [7:0] setup_cmd(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = 8'h2C;
            2'd1:    v = 8'h0C;
            2'd2:    v = 8'h06;
            default: v = 8'h01;
        endcase
        return v;
    endfunction

endpackage

/* rtl/clcd_ctrl.sv */
module clcd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            operation,
    input  clcd_pkg::clcd_stat_t  stat,
    output clcd_pkg::clcd_cmd_t   cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_STATUS = 3'd1;
    localparam logic [2:0] S_RCMD   = 3'd2;
    localparam logic [2:0] S_RRD    = 3'd3;
    localparam logic [2:0] S_RDATA  = 3'd4;
    localparam logic [2:0] S_INIB   = 3'd5;
    localparam logic [2:0] S_ICMD   = 3'd6;

    localparam logic [clcd_pkg::COL_W-1:0] COL_LAST =
        clcd_pkg::COL_W'(clcd_pkg::COLUMNS - 1);

    logic [2:0]                    state_reg, state_next;
    logic [1:0]                    op_reg, op_next;
    logic                          row_reg, row_next;
    logic [clcd_pkg::COL_W-1:0]    col_reg, col_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= clcd_pkg::OP_WRITE;
            row_reg   <= 1'b0;
            col_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        row_next   = row_reg;
        col_next   = col_reg;

        cmd           = '0;
        cmd.kind      = clcd_pkg::KIND_BYTE;
        cmd.rs        = clcd_pkg::RS_CMD;
        cmd.rd_row    = row_reg;
        cmd.rd_col    = col_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    op_next  = operation;
                    row_next = 1'b0;
                    col_next = '0;
                    unique case (operation) inside
                        clcd_pkg::OP_WRITE,
                        clcd_pkg::OP_CLEAR:   state_next = S_STATUS;
                        clcd_pkg::OP_REFRESH: state_next = S_RCMD;
                        default:              state_next = S_INIB;
                    endcase
                end
            end
            S_STATUS:
            begin
                cmd.load     = stat.slot_free;
                cmd.kind     = clcd_pkg::KIND_STATUS;
                cmd.last     = 1'b1;
                cmd.do_write = stat.slot_free && (op_reg == clcd_pkg::OP_WRITE);
                cmd.do_clear = stat.slot_free && (op_reg == clcd_pkg::OP_CLEAR);
                if (stat.slot_free)
                    state_next = S_IDLE;
            end
            S_RCMD:
            begin
                cmd.load      = stat.slot_free;
                cmd.value     = row_reg ? clcd_pkg::CMD_ROW1 : clcd_pkg::CMD_ROW0;
                cmd.clr_dirty = stat.slot_free;
                if (stat.slot_free)
                    state_next = S_RRD;
            end
            S_RRD:
            begin
                // wait state for the registered buffer read to land
                state_next = S_RDATA;
            end
            S_RDATA:
            begin
                cmd.load      = stat.slot_free;
                cmd.rs        = clcd_pkg::RS_DATA;
                cmd.use_mem   = 1'b1;
                cmd.clr_dirty = stat.slot_free;
                cmd.last      = row_reg && (col_reg == COL_LAST);
                if (stat.slot_free)
                begin
                    if (col_reg == COL_LAST)
                    begin
                        col_next = '0;
                        if (row_reg)
                            state_next = S_IDLE;
                        else
                        begin
                            row_next   = 1'b1;
                            state_next = S_RCMD;
                        end
                    end
                    else
                    begin
                        col_next   = col_reg + 1'b1;
                        state_next = S_RRD;
                    end
                end
            end
            S_INIB:
            begin
                cmd.load  = stat.slot_free;
                cmd.kind  = clcd_pkg::KIND_NIBBLE;
                cmd.value = clcd_pkg::START_NIBBLE;
                if (stat.slot_free)
                begin
                    col_next   = '0;
                    state_next = S_ICMD;
                end
            end
            S_ICMD:
            begin
                cmd.load  = stat.slot_free;
                cmd.value = clcd_pkg::setup_cmd(col_reg[1:0]);
                cmd.last  = (col_reg[1:0] == 2'd3);
                if (stat.slot_free)
                begin
                    if (col_reg[1:0] == 2'd3)
                        state_next = S_IDLE;
                    else
                        col_next = col_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/clcd_dpath.sv */
module clcd_dpath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [4:0]           column,
    input  logic [1:0]           row,
    input  logic [7:0]           character,
    input  clcd_pkg::clcd_cmd_t  cmd,
    output clcd_pkg::clcd_stat_t stat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           kind,
    output logic                 register_select,
    output logic [7:0]           value,
    output logic                 accepted,
    output logic                 dirty,
    output logic                 last
);

    localparam int AW = clcd_pkg::AW;

    logic [7:0]                 mem [clcd_pkg::DEPTH];
    logic [clcd_pkg::DEPTH-1:0] vld_reg;
    logic [7:0]                 rd_data_reg;
    logic                       rd_vld_reg;

    logic [4:0] col_in_reg;
    logic [1:0] row_in_reg;
    logic [7:0] char_in_reg;

    logic       dirty_reg, dirty_next;
    logic       out_valid_reg;
    logic [1:0] kind_reg;
    logic       rs_reg;
    logic [7:0] value_reg;
    logic       accepted_reg;
    logic       dirty_out_reg;
    logic       last_reg;

    logic          pos_ok;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            col_in_reg  <= column;
            row_in_reg  <= row;
            char_in_reg <= character;
        end
    end

    assign pos_ok = (col_in_reg != 5'd0) && (row_in_reg != 2'd0)
                 && ({27'd0, col_in_reg} <= 32'(clcd_pkg::COLUMNS))
                 && ({30'd0, row_in_reg} <= 32'(clcd_pkg::ROWS));
    assign wr_en  = cmd.do_write && pos_ok;

    // rows are 1-based here; only row 1 or 2 reaches the write
    assign wr_addr = ((row_in_reg == 2'd2) ? AW'(clcd_pkg::COLUMNS) : AW'(0))
                   + AW'(col_in_reg - 5'd1);
    assign rd_addr = (cmd.rd_row ? AW'(clcd_pkg::COLUMNS) : AW'(0)) + AW'(cmd.rd_col);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= char_in_reg;
        rd_data_reg <= mem[rd_addr];
    end

    // entries not written since reset or clear read back as space
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.do_clear)
                vld_reg <= '0;
            else if (wr_en)
                vld_reg[wr_addr] <= 1'b1;
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    always_comb
    begin
        dirty_next = dirty_reg;
        if (wr_en || cmd.do_clear)
            dirty_next = 1'b1;
        else if (cmd.clr_dirty)
            dirty_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dirty_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            dirty_reg <= dirty_next;
            if (cmd.load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg      <= cmd.kind;
            rs_reg        <= cmd.rs;
            value_reg     <= cmd.use_mem ? (rd_vld_reg ? rd_data_reg : clcd_pkg::SPACE_CHAR)
                                         : cmd.value;
            accepted_reg  <= wr_en;
            dirty_out_reg <= dirty_next;
            last_reg      <= cmd.last;
        end
    end

    assign stat.slot_free = !out_valid_reg || out_ready;

    assign out_valid       = out_valid_reg;
    assign kind            = kind_reg;
    assign register_select = rs_reg;
    assign value           = value_reg;
    assign accepted        = accepted_reg;
    assign dirty           = dirty_out_reg;
    assign last            = last_reg;

endmodule

/* rtl/char_lcd_refresh_controller.sv */
// Character LCD frame buffer and refresh sequencer.
// Input channel (in_valid/in_ready) carries one command transaction:
// operation, column, row, character. Output channel (out_valid/out_ready)
// carries the bus writes and status words, the final one marked by last.
// One command is worked at a time; in_ready is high only when idle.
// Write_char and clear give one status transaction and return to idle as
// it is loaded. Init gives 5 transactions, one per cycle while the
// receiver does not stall, and returns to idle as the last is loaded.
// Refresh gives 2*COLUMNS+2 transactions (42 at 20 columns); before each
// data byte the sequencer passes a wait state for the registered buffer
// read, and it returns to idle, ready for the next command, as the last
// byte is loaded.
// Reset empties the buffer at once (all positions read as space through
// per-entry valid flags), clears dirty and drops out_valid.
// A stalled receiver holds the output register; the sequencer waits and
// resumes when the result is taken, with nothing lost or repeated.
module char_lcd_refresh_controller (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] operation,
    input  logic [4:0] column,
    input  logic [1:0] row,
    input  logic [7:0] character,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic       register_select,
    output logic [7:0] value,
    output logic       accepted,
    output logic       dirty,
    output logic       last
);

    clcd_pkg::clcd_cmd_t  cmd;
    clcd_pkg::clcd_stat_t stat;

    clcd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .stat      (stat),
        .cmd       (cmd)
    );

    clcd_dpath u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .column          (column),
        .row             (row),
        .character       (character),
        .cmd             (cmd),
        .stat            (stat),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .kind            (kind),
        .register_select (register_select),
        .value           (value),
        .accepted        (accepted),
        .dirty           (dirty),
        .last            (last)
    );

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;

    typedef struct {
        logic [1:0]  op;
        logic [4:0]  col;
        logic [1:0]  row;
        logic [7:0]  ch;
        int unsigned gap;
        bit          hold;
    } lcd_cmd_t;

    typedef struct {
        logic [1:0] kind;
        logic       rs;
        logic [7:0] value;
        logic       accepted;
        logic       dirty;
        logic       last;
    } bus_word_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [1:0] operation = clcd_pkg::OP_WRITE;
    logic [4:0] column = '0;
    logic [1:0] row = '0;
    logic [7:0] character = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] kind;
    logic       register_select;
    logic [7:0] value;
    logic       accepted;
    logic       dirty;
    logic       last;

    char_lcd_refresh_controller u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .column          (column),
        .row             (row),
        .character       (character),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .kind            (kind),
        .register_select (register_select),
        .value           (value),
        .accepted        (accepted),
        .dirty           (dirty),
        .last            (last)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    lcd_cmd_t    cmd_fifo[$];
    bus_word_t   want_words[$];
    logic [7:0]  shadow_fb [0:clcd_pkg::DEPTH-1];
    logic        shadow_dirty;
    int unsigned errors = 0;
    logic        in_took = 1'b0;
    logic        out_took = 1'b0;
    int unsigned send_wait = 0;
    int unsigned stall_left = 0;
    int unsigned calm_left = 0;

    function automatic bus_word_t bus_word(logic [1:0] k, logic rs, logic [7:0] v,
                                           logic acc, logic fin);
        bus_word_t w;
        w.kind     = k;
        w.rs       = rs;
        w.value    = v;
        w.accepted = acc;
        w.dirty    = shadow_dirty;
        w.last     = fin;
        return w;
    endfunction

    // expected bus words for one command, updating the shadow buffer
    task automatic predict_command(logic [1:0] op, logic [4:0] col, logic [1:0] rw,
                                   logic [7:0] ch);
        logic ok;
        ok = 1'b0;
        case (op)
            clcd_pkg::OP_WRITE:
            begin
                if (col != 0 && rw != 0 && col <= clcd_pkg::COLUMNS && rw <= clcd_pkg::ROWS)
                begin
                    shadow_fb[(rw - 1) * clcd_pkg::COLUMNS + (col - 1)] = ch;
                    shadow_dirty = 1'b1;
                    ok = 1'b1;
                end
                want_words.push_back(bus_word(clcd_pkg::KIND_STATUS, clcd_pkg::RS_CMD,
                                              8'h00, ok, 1'b1));
            end
            clcd_pkg::OP_CLEAR:
            begin
                for (int i = 0; i < clcd_pkg::DEPTH; i++)
                    shadow_fb[i] = clcd_pkg::SPACE_CHAR;
                shadow_dirty = 1'b1;
                want_words.push_back(bus_word(clcd_pkg::KIND_STATUS, clcd_pkg::RS_CMD,
                                              8'h00, 1'b0, 1'b1));
            end
            clcd_pkg::OP_REFRESH:
            begin
                shadow_dirty = 1'b0;
                for (int r = 0; r < clcd_pkg::ROWS; r++)
                begin
                    want_words.push_back(bus_word(clcd_pkg::KIND_BYTE, clcd_pkg::RS_CMD,
                                                  r == 0 ? clcd_pkg::CMD_ROW0
                                                         : clcd_pkg::CMD_ROW1,
                                                  1'b0, 1'b0));
                    for (int c = 0; c < clcd_pkg::COLUMNS; c++)
                        want_words.push_back(bus_word(clcd_pkg::KIND_BYTE, clcd_pkg::RS_DATA,
                                                      shadow_fb[r * clcd_pkg::COLUMNS + c],
                                                      1'b0,
                                                      r == clcd_pkg::ROWS - 1 &&
                                                      c == clcd_pkg::COLUMNS - 1));
                end
            end
            default:
            begin
                want_words.push_back(bus_word(clcd_pkg::KIND_NIBBLE, clcd_pkg::RS_CMD,
                                              clcd_pkg::START_NIBBLE, 1'b0, 1'b0));
                for (int i = 0; i < 4; i++)
                    want_words.push_back(bus_word(clcd_pkg::KIND_BYTE, clcd_pkg::RS_CMD,
                                                  clcd_pkg::setup_cmd(2'(i)), 1'b0,
                                                  i == 3));
            end
        endcase
    endtask

    function automatic void check_field(string name, int unsigned exp, int unsigned got);
        if (exp != got)
        begin
            $display("%0t: %s expected %0h got %0h", $time, name, exp, got);
            errors++;
        end
    endfunction

    // monitor: checks output transactions, predicts on input transactions
    always @(posedge clk)
    begin : monitor
        bus_word_t w;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (want_words.size() == 0)
                begin
                    $display("%0t: unexpected transaction expected none got kind %0d value %0h",
                             $time, kind, value);
                    errors++;
                end
                else
                begin
                    w = want_words.pop_front();
                    check_field("kind", w.kind, kind);
                    check_field("register_select", w.rs, register_select);
                    check_field("value", w.value, value);
                    check_field("accepted", w.accepted, accepted);
                    check_field("dirty", w.dirty, dirty);
                    check_field("last", w.last, last);
                end
            end
            if (in_valid && in_ready)
                predict_command(operation, column, row, character);
            in_took  <= in_valid && in_ready;
            out_took <= out_valid && out_ready;
        end
    end

    // command driver
    always @(negedge clk)
    begin : driver
        lcd_cmd_t c;
        if (rst_n && (!in_valid || in_took))
        begin
            if (cmd_fifo.size() != 0 && send_wait < cmd_fifo[0].gap)
            begin
                in_valid  <= 1'b0;
                send_wait <= send_wait + 1;
            end
            else if (cmd_fifo.size() != 0 && !(cmd_fifo[0].hold && want_words.size() != 0))
            begin
                c = cmd_fifo.pop_front();
                operation <= c.op;
                column    <= c.col;
                row       <= c.row;
                character <= c.ch;
                in_valid  <= 1'b1;
                send_wait <= 0;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver back-pressure, with occasional runs of no stall
    always @(negedge clk)
    begin : receiver
        int unsigned w;
        if (rst_n)
        begin
            if (out_took)
            begin
                if (calm_left != 0)
                begin
                    w = 0;
                    calm_left <= calm_left - 1;
                end
                else
                begin
                    w = $urandom_range(0, 5);
                    if ($urandom_range(0, 39) == 0)
                        calm_left <= 30;
                end
                out_ready  <= (w == 0);
                stall_left <= (w == 0) ? 0 : w - 1;
            end
            else if (stall_left != 0)
            begin
                out_ready  <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic add_cmd(logic [1:0] op, logic [4:0] col, logic [1:0] rw, logic [7:0] ch,
                           int unsigned gap, bit hold);
        lcd_cmd_t c;
        c.op   = op;
        c.col  = col;
        c.row  = rw;
        c.ch   = ch;
        c.gap  = gap;
        c.hold = hold;
        cmd_fifo.push_back(c);
    endtask

    initial
    begin : stimulus
        int unsigned pick;
        bit          calm;
        for (int i = 0; i < clcd_pkg::DEPTH; i++)
            shadow_fb[i] = clcd_pkg::SPACE_CHAR;
        shadow_dirty = 1'b0;

        // directed: corners, ignored positions, each operation
        add_cmd(clcd_pkg::OP_REFRESH, 5'd0, 2'd0, 8'h00, $urandom_range(0, 5), 1'b0);
        add_cmd(clcd_pkg::OP_INIT, 5'd31, 2'd3, 8'hFF, $urandom_range(0, 5), 1'b0);
        add_cmd(clcd_pkg::OP_WRITE, 5'd1, 2'd1, 8'h00, $urandom_range(0, 5), 1'b0);
        add_cmd(clcd_pkg::OP_WRITE, 5'd20, 2'd2, 8'hFF, $urandom_range(0, 5), 1'b0);
        add_cmd(clcd_pkg::OP_WRITE, 5'd0, 2'd1, 8'h41, $urandom_range(0, 5), 1'b0);
        add_cmd(clcd_pkg::OP_WRITE, 5'd5, 2'd0, 8'h42, $urandom_range(0, 5), 1'b0);
        add_cmd(clcd_pkg::OP_WRITE, 5'd21, 2'd1, 8'h43, $urandom_range(0, 5), 1'b0);
        add_cmd(clcd_pkg::OP_WRITE, 5'd31, 2'd2, 8'h44, $urandom_range(0, 5), 1'b0);
        add_cmd(clcd_pkg::OP_WRITE, 5'd3, 2'd3, 8'h45, $urandom_range(0, 5), 1'b0);
        add_cmd(clcd_pkg::OP_WRITE, 5'd0, 2'd0, 8'hAA, $urandom_range(0, 5), 1'b0);
        add_cmd(clcd_pkg::OP_WRITE, 5'd20, 2'd1, 8'h55, $urandom_range(0, 5), 1'b0);
        add_cmd(clcd_pkg::OP_WRITE, 5'd1, 2'd2, 8'h80, $urandom_range(0, 5), 1'b0);
        add_cmd(clcd_pkg::OP_REFRESH, 5'd0, 2'd0, 8'h00, $urandom_range(0, 5), 1'b0);
        add_cmd(clcd_pkg::OP_WRITE, 5'd10, 2'd1, 8'h7F, 0, 1'b1);
        add_cmd(clcd_pkg::OP_REFRESH, 5'd0, 2'd0, 8'h00, $urandom_range(0, 5), 1'b0);
        add_cmd(clcd_pkg::OP_CLEAR, 5'd0, 2'd0, 8'h00, $urandom_range(0, 5), 1'b0);
        add_cmd(clcd_pkg::OP_REFRESH, 5'd0, 2'd0, 8'h00, $urandom_range(0, 5), 1'b0);
        add_cmd(clcd_pkg::OP_WRITE, 5'd31, 2'd3, 8'hFF, $urandom_range(0, 5), 1'b0);
        add_cmd(clcd_pkg::OP_INIT, 5'd0, 2'd0, 8'h00, $urandom_range(0, 5), 1'b0);
        add_cmd(clcd_pkg::OP_WRITE, 5'd2, 2'd1, 8'h01, $urandom_range(0, 5), 1'b0);
        add_cmd(clcd_pkg::OP_INIT, 5'd0, 2'd0, 8'h00, $urandom_range(0, 5), 1'b0);
        add_cmd(clcd_pkg::OP_CLEAR, 5'd17, 2'd2, 8'hC3, $urandom_range(0, 5), 1'b0);
        add_cmd(clcd_pkg::OP_REFRESH, 5'd0, 2'd0, 8'h00, $urandom_range(0, 5), 1'b0);

        // random: mostly writes, largely in range, mixed with clears, inits and refreshes
        calm = 1'b0;
        for (int n = 0; n < 147; n++)
        begin
            lcd_cmd_t c;
            if (n % 25 == 0)
                calm = ($urandom_range(0, 2) == 0);
            c.ch   = 8'($urandom_range(0, 255));
            c.gap  = calm ? 0 : $urandom_range(0, 5);
            c.hold = ($urandom_range(0, 39) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                c.op = clcd_pkg::OP_WRITE;
                if ($urandom_range(0, 4) != 0)
                begin
                    c.col = 5'($urandom_range(1, clcd_pkg::COLUMNS));
                    c.row = 2'($urandom_range(1, clcd_pkg::ROWS));
                end
                else
                begin
                    c.col = 5'($urandom_range(0, 31));
                    c.row = 2'($urandom_range(0, 3));
                end
            end
            else
            begin
                if (pick < 62)
                    c.op = clcd_pkg::OP_CLEAR;
                else if (pick < 85)
                    c.op = clcd_pkg::OP_REFRESH;
                else
                    c.op = clcd_pkg::OP_INIT;
                c.col = 5'($urandom_range(0, 31));
                c.row = 2'($urandom_range(0, 3));
            end
            cmd_fifo.push_back(c);
        end

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        while (cmd_fifo.size() != 0 || in_valid || want_words.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (errors == 0)
            $display("char_lcd_refresh_controller: match");
        else
            $display("char_lcd_refresh_controller: mismatch");
        $finish;
    end

    initial
    begin : watchdog
        #5000000;
        $display("char_lcd_refresh_controller: mismatch");
        $finish;
    end

endmodule

/* sim.f */
rtl/clcd_pkg.sv
rtl/clcd_ctrl.sv
rtl/clcd_dpath.sv
rtl/char_lcd_refresh_controller.sv
sim/tb.sv
